// ===== design/lobs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobs_pkg
// Shared types and constants for the lidar obstacle-avoidance mode machine.
// ----------------------------------------------------------------------------
package lobs_pkg;

    localparam int BEAM_CNT_W = 11;
    localparam int INDEX_W    = 10;
    localparam int DIST_W     = 16;
    localparam int SPEED_W    = 16;
    localparam int TIMER_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [BEAM_CNT_W-1:0] MAX_BEAMS  = 11'd1024;
    localparam logic [TIMER_W-1:0]    SPIN_TICKS = 16'd30;
    localparam logic [TIMER_W-1:0]    TIMER_TOP  = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_COUNT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WANDER_INTERVAL = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EVADE_TICKS     = 8'd7;

    typedef enum logic [1:0] {
        MODE_FWD   = 2'd0,
        MODE_EVADE = 2'd1,
        MODE_SPIN  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [BEAM_CNT_W-1:0]     beam_count;
        logic [DIST_W-1:0]         min_range_mm;
        logic [DIST_W-1:0]         max_valid_mm;
        logic [DIST_W-1:0]         clearance_mm;
        logic signed [SPEED_W-1:0] forward_speed;
        logic signed [SPEED_W-1:0] turn_speed;
        logic [TIMER_W-1:0]        wander_interval;
        logic [TIMER_W-1:0]        evade_ticks;
    } cfg_t;

    typedef struct packed {
        logic set_left;
        logic set_right;
    } blk_t;

    typedef struct packed {
        logic  left_blocked;
        logic  right_blocked;
        mode_t mode;
    } status_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
    } result_t;

endpackage : lobs_pkg
`default_nettype wire

// ===== design/lobs_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobs_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module lobs_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [lobs_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [lobs_pkg::CFG_DATA_W-1:0] wr_data,
    output lobs_pkg::cfg_t                       cfg
);
    import lobs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.beam_count      <= 11'd512;
            cfg_reg.min_range_mm    <= 16'd0;
            cfg_reg.max_valid_mm    <= 16'd65535;
            cfg_reg.clearance_mm    <= 16'd100;
            cfg_reg.forward_speed   <= 16'sd768;
            cfg_reg.turn_speed      <= 16'sd512;
            cfg_reg.wander_interval <= 16'd200;
            cfg_reg.evade_ticks     <= 16'd50;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_BEAM_COUNT:      cfg_reg.beam_count      <= wr_data[BEAM_CNT_W-1:0];
                REG_MIN_RANGE:       cfg_reg.min_range_mm    <= wr_data;
                REG_MAX_VALID:       cfg_reg.max_valid_mm    <= wr_data;
                REG_CLEARANCE:       cfg_reg.clearance_mm    <= wr_data;
                REG_FORWARD_SPEED:   cfg_reg.forward_speed   <= wr_data;
                REG_TURN_SPEED:      cfg_reg.turn_speed      <= wr_data;
                REG_WANDER_INTERVAL: cfg_reg.wander_interval <= wr_data;
                REG_EVADE_TICKS:     cfg_reg.evade_ticks     <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : lobs_cfg_regs
`default_nettype wire

// ===== design/lobs_beam_gate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobs_beam_gate
// Range window and front-sector test for one beam; flags the blocked side.
// ----------------------------------------------------------------------------
module lobs_beam_gate (
    input  wire logic                         beam_en,
    input  wire logic [lobs_pkg::INDEX_W-1:0] beam_index,
    input  wire logic [lobs_pkg::DIST_W-1:0]  distance_mm,
    input  lobs_pkg::cfg_t                    cfg,
    output lobs_pkg::blk_t                    blk
);
    import lobs_pkg::*;

    logic [BEAM_CNT_W-1:0] n_beams;
    logic [BEAM_CNT_W-1:0] mid;
    logic [BEAM_CNT_W-1:0] quarter;
    logic [BEAM_CNT_W-1:0] sector_lo;
    logic [BEAM_CNT_W-1:0] sector_hi;
    logic [BEAM_CNT_W-1:0] idx;
    logic                  usable;
    logic                  front_hit;

    always_comb begin
        n_beams   = (cfg.beam_count > MAX_BEAMS) ? MAX_BEAMS : cfg.beam_count;
        mid       = {1'b0, n_beams[BEAM_CNT_W-1:1]};
        quarter   = {2'b00, n_beams[BEAM_CNT_W-1:2]};
        // mid + quarter stays at or below the beam count, so no carry is lost
        sector_lo = mid - quarter;
        sector_hi = mid + quarter;
        idx       = {{(BEAM_CNT_W-INDEX_W){1'b0}}, beam_index};
        usable    = (idx < n_beams) && (distance_mm <= cfg.max_valid_mm)
                    && (distance_mm >= cfg.min_range_mm);
        front_hit = beam_en && usable && (idx >= sector_lo) && (idx <= sector_hi)
                    && (distance_mm < cfg.clearance_mm);
        blk.set_right = front_hit && (idx < mid);
        blk.set_left  = front_hit && !(idx < mid);
    end

endmodule : lobs_beam_gate
`default_nettype wire

// ===== design/lobs_mode_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lobs_mode_step
// Drive mode machine: blocked flags, tick timer, turn direction, wheel speeds.
// ----------------------------------------------------------------------------
module lobs_mode_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        scan_en,
    input  wire logic        random_bit,
    input  lobs_pkg::blk_t   blk,
    input  lobs_pkg::cfg_t   cfg,
    output lobs_pkg::result_t result,
    output lobs_pkg::status_t status
);
    import lobs_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic                 turn_left_reg, turn_left_next;
    logic                 left_blk_reg, left_blk_next;
    logic                 right_blk_reg, right_blk_next;
    logic                 blocked;
    logic signed [SPEED_W-1:0] turn_neg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_FWD;
            timer_reg     <= '0;
            turn_left_reg <= 1'b0;
            left_blk_reg  <= 1'b0;
            right_blk_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            timer_reg     <= timer_next;
            turn_left_reg <= turn_left_next;
            left_blk_reg  <= left_blk_next;
            right_blk_reg <= right_blk_next;
        end
    end

    always_comb begin
        blocked  = left_blk_reg || right_blk_reg;
        // negating the most negative speed saturates
        turn_neg = (cfg.turn_speed == 16'sh8000) ? 16'sh7FFF : -cfg.turn_speed;

        mode_next      = mode_reg;
        timer_next     = timer_reg;
        turn_left_next = turn_left_reg;
        left_blk_next  = left_blk_reg || blk.set_left;
        right_blk_next = right_blk_reg || blk.set_right;

        // speeds follow the mode held before the step
        unique case (mode_reg)
            MODE_EVADE, MODE_SPIN: begin
                result.left_speed  = turn_left_reg ? turn_neg : cfg.turn_speed;
                result.right_speed = turn_left_reg ? cfg.turn_speed : turn_neg;
            end
            default: begin
                result.left_speed  = cfg.forward_speed;
                result.right_speed = cfg.forward_speed;
            end
        endcase

        if (scan_en) begin
            left_blk_next  = 1'b0;
            right_blk_next = 1'b0;
            unique case (mode_reg)
                MODE_EVADE, MODE_SPIN: begin
                    if (mode_reg == MODE_SPIN && blocked) begin
                        mode_next  = MODE_EVADE;
                        timer_next = cfg.evade_ticks;
                    end else if (timer_reg == '0) begin
                        mode_next = MODE_FWD;
                    end else begin
                        timer_next = timer_reg - 16'd1;
                    end
                end
                default: begin
                    if (blocked) begin
                        mode_next      = MODE_EVADE;
                        timer_next     = cfg.evade_ticks;
                        turn_left_next = right_blk_reg;
                    end else if (timer_reg > cfg.wander_interval) begin
                        mode_next      = MODE_SPIN;
                        timer_next     = SPIN_TICKS;
                        turn_left_next = random_bit;
                    end else begin
                        mode_next = MODE_FWD;
                        if (timer_reg != TIMER_TOP) begin
                            timer_next = timer_reg + 16'd1;
                        end
                    end
                end
            endcase
        end

        result.mode          = mode_next;
        status.left_blocked  = left_blk_reg;
        status.right_blocked = right_blk_reg;
        status.mode          = mode_reg;
    end

endmodule : lobs_mode_step
`default_nettype wire

// ===== design/lidar_obstacle_avoid_fsm_unit.sv =====
`default_nettype none
// Path: a scan-end item is registered in the input register, then in the result register.
// Throughput: one item per cycle while no scan-end item waits on a held result; the input
//   register and the result register decouple the channels, and a beam item never waits on the result side.
// Reset: aresetn synchronous, active low; clears both valid bits, the mode
//   machine (forward, timer zero, turn right, flags clear) and loads the
//   configuration register defaults.
// ----------------------------------------------------------------------------
// lidar_obstacle_avoid_fsm_unit
// Lidar beam screening and forward/evade/spin drive mode machine.
// ----------------------------------------------------------------------------
module lidar_obstacle_avoid_fsm_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // beam_index[9:0], distance_mm[25:10], random_bit[26]
    input  wire logic [0:0]  s_tuser,   // action[0]
    // results
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [39:0] m_tdata    // left_speed[15:0], right_speed[31:16], mode[33:32]
);
    import lobs_pkg::*;

    cfg_t    cfg;
    blk_t    blk;
    result_t step_res;
    status_t status;

    logic                in_valid_reg;
    logic                in_action_reg;
    logic [INDEX_W-1:0]  in_index_reg;
    logic [DIST_W-1:0]   in_dist_reg;
    logic                in_rand_reg;
    logic                m_valid_reg;
    result_t             m_data_reg;
    logic                s_accept;
    logic                advance;
    logic                scan_adv;

    assign cfg_ready = 1'b1;

    lobs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // a beam item retires without touching the result register
    assign advance  = in_valid_reg && (!in_action_reg || !m_valid_reg || m_tready);
    assign scan_adv = advance && in_action_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser[0];
            in_index_reg  <= s_tdata[9:0];
            in_dist_reg   <= s_tdata[25:10];
            in_rand_reg   <= s_tdata[26];
        end
    end

    lobs_beam_gate u_gate (
        .beam_en     (advance && !in_action_reg),
        .beam_index  (in_index_reg),
        .distance_mm (in_dist_reg),
        .cfg         (cfg),
        .blk         (blk)
    );

    lobs_mode_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_en    (scan_adv),
        .random_bit (in_rand_reg),
        .blk        (blk),
        .cfg        (cfg),
        .result     (step_res),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (scan_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_adv) begin
            m_data_reg <= step_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

`ifndef SYNTHESIS
    // hold the input side only while a result is stuck behind a scan-end item
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !s_tready) |-> (in_action_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_adv |=> (!status.left_blocked && !status.right_blocked))
        else $error("blocked flags survive a scan end");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_adv |=> m_tvalid)
        else $error("scan end gave no result");

    a_beam_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_action_reg && !m_tvalid) |=> !m_tvalid)
        else $error("beam item produced a result");
`endif

endmodule : lidar_obstacle_avoid_fsm_unit
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar obstacle-avoidance mode machine. A queue of
// beam and scan-end items feeds a stream driver; every accepted item runs
// through a local model of the beam screening and the forward/evade/spin
// machine, and each wheel command it predicts is checked against the result
// stream. Phases change the register settings and the idle/stall pattern on
// both channels, and one phase holds the result side off long enough to back
// up the input side.
// ----------------------------------------------------------------------------
module tb_top;
    import lobs_pkg::*;

    localparam logic        ACT_BEAM      = 1'b0;
    localparam logic        ACT_SCAN_END  = 1'b1;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 8;

    typedef struct packed {
        logic        tick;
        logic        rnd;
        logic [15:0] dist_mm;
        logic [9:0]  idx;
    } scan_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata   = '0;   // beam_index[9:0], distance_mm[25:10], random_bit[26]
    logic [0:0]  s_tuser   = '0;   // action[0]
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [39:0] m_tdata;          // left_speed[15:0], right_speed[31:16], mode[33:32]

    // local copy of the registers and of the drive state
    cfg_t        shadow_cfg;
    mode_t       drv_mode;
    logic [15:0] drv_timer;
    logic        turn_left_q;
    logic        left_blk;
    logic        right_blk;

    scan_item_t  pending_items[$];
    result_t     expected_cmds[$];
    scan_item_t  offered;

    int          err_cnt        = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_req       = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int unsigned cycle_cnt      = 0;

    lidar_obstacle_avoid_fsm_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Screen a beam or step the mode machine; queue the wheel command of a scan end.
    function automatic void predict_drive(scan_item_t it);
        int                 n;
        int                 mid;
        int                 qtr;
        int                 neg_v;
        logic signed [15:0] t_pos;
        logic signed [15:0] t_neg;
        logic               blocked;
        result_t            cmd;
        if (it.tick == ACT_BEAM) begin
            n   = (shadow_cfg.beam_count > MAX_BEAMS) ? int'(MAX_BEAMS)
                                                       : int'(shadow_cfg.beam_count);
            mid = n / 2;
            qtr = n / 4;
            if (it.idx >= n || it.dist_mm > shadow_cfg.max_valid_mm
                    || it.dist_mm < shadow_cfg.min_range_mm)
                return;
            if (it.idx >= mid - qtr && it.idx <= mid + qtr
                    && it.dist_mm < shadow_cfg.clearance_mm) begin
                if (it.idx < mid)
                    right_blk = 1'b1;
                else
                    left_blk = 1'b1;
            end
            return;
        end

        blocked = left_blk | right_blk;
        // negating the most negative speed saturates
        neg_v = -int'(shadow_cfg.turn_speed);
        if (neg_v > 32767)
            neg_v = 32767;
        t_pos = shadow_cfg.turn_speed;
        t_neg = neg_v[15:0];

        if (drv_mode == MODE_EVADE || drv_mode == MODE_SPIN) begin
            cmd.left_speed  = turn_left_q ? t_neg : t_pos;
            cmd.right_speed = turn_left_q ? t_pos : t_neg;
            if (drv_mode == MODE_SPIN && blocked) begin
                drv_mode  = MODE_EVADE;
                drv_timer = shadow_cfg.evade_ticks;
            end else if (drv_timer == 0) begin
                drv_mode = MODE_FWD;
            end else begin
                drv_timer = drv_timer - 1'b1;
            end
        end else begin
            cmd.left_speed  = shadow_cfg.forward_speed;
            cmd.right_speed = shadow_cfg.forward_speed;
            if (blocked) begin
                drv_mode    = MODE_EVADE;
                drv_timer   = shadow_cfg.evade_ticks;
                turn_left_q = right_blk;
            end else if (drv_timer > shadow_cfg.wander_interval) begin
                drv_mode    = MODE_SPIN;
                drv_timer   = SPIN_TICKS;
                turn_left_q = it.rnd;
            end else begin
                drv_mode = MODE_FWD;
                if (drv_timer != TIMER_TOP)
                    drv_timer = drv_timer + 1'b1;
            end
        end

        left_blk  = 1'b0;
        right_blk = 1'b0;
        cmd.mode  = drv_mode;
        expected_cmds.push_back(cmd);
    endfunction

    function automatic void add_item(logic tick, int idx, int dist_v, logic rnd);
        scan_item_t it;
        it.tick    = tick;
        it.idx     = idx[9:0];
        it.dist_mm = dist_v[15:0];
        it.rnd     = rnd;
        pending_items.push_back(it);
    endfunction

    // input driver: hold an offered item until its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_drive(offered);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, offered.rnd, offered.dist_mm, offered.idx};
                    s_tuser  <= offered.tick;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver pacing
    always @(posedge aclk) begin : result_mon
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[33:0];
                if (expected_cmds.size() == 0) begin
                    $error("result with nothing expected: left_speed %0d right_speed %0d mode %0d",
                           got.left_speed, got.right_speed, got.mode);
                    err_cnt++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.left_speed !== want.left_speed) begin
                        $error("left_speed: expected %0d, got %0d",
                               want.left_speed, got.left_speed);
                        err_cnt++;
                    end
                    if (got.right_speed !== want.right_speed) begin
                        $error("right_speed: expected %0d, got %0d",
                               want.right_speed, got.right_speed);
                        err_cnt++;
                    end
                    if (got.mode !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, got.mode);
                        err_cnt++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_BEAM_COUNT:      shadow_cfg.beam_count      = val[10:0];
            REG_MIN_RANGE:       shadow_cfg.min_range_mm    = val;
            REG_MAX_VALID:       shadow_cfg.max_valid_mm    = val;
            REG_CLEARANCE:       shadow_cfg.clearance_mm    = val;
            REG_FORWARD_SPEED:   shadow_cfg.forward_speed   = val;
            REG_TURN_SPEED:      shadow_cfg.turn_speed      = val;
            REG_WANDER_INTERVAL: shadow_cfg.wander_interval = val;
            REG_EVADE_TICKS:     shadow_cfg.evade_ticks     = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int bc, int mn, int mx, int cl, int fw, int tu,
                                  int wi, int ev);
        write_reg(REG_BEAM_COUNT,      16'(bc));
        write_reg(REG_MIN_RANGE,       16'(mn));
        write_reg(REG_MAX_VALID,       16'(mx));
        write_reg(REG_CLEARANCE,       16'(cl));
        write_reg(REG_FORWARD_SPEED,   16'(fw));
        write_reg(REG_TURN_SPEED,      16'(tu));
        write_reg(REG_WANDER_INTERVAL, 16'(wi));
        write_reg(REG_EVADE_TICKS,     16'(ev));
    endtask

    // Wait until every item is taken and every command is back, then give the
    // last item time to drain out of the input register.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_cmds.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Queue whole scans (beams, then a scan end) until about count items are in.
    task automatic queue_scans(int count);
        int n;
        int mid;
        int qtr;
        int nb;
        int kind;
        int iv;
        int dv;
        int added;
        added = 0;
        while (added < count) begin
            n    = (shadow_cfg.beam_count > MAX_BEAMS) ? int'(MAX_BEAMS)
                                                        : int'(shadow_cfg.beam_count);
            mid  = n / 2;
            qtr  = n / 4;
            nb   = $urandom_range(0, 6);
            kind = $urandom_range(0, 9);
            for (int b = 0; b < nb; b++) begin
                if (kind < 4) begin
                    // clean beam: off the front sector, or far enough away
                    if ($urandom_range(1) == 0 || shadow_cfg.clearance_mm == 0) begin
                        iv = $urandom_range(0, mid - qtr - 1);
                        dv = $urandom_range(0, 65535);
                    end else begin
                        iv = $urandom_range(mid - qtr, mid + qtr);
                        dv = $urandom_range(shadow_cfg.clearance_mm, 65535);
                    end
                end else if (kind < 9) begin
                    case ($urandom_range(0, 6))
                        0: iv = $urandom_range(0, 1023);
                        1: iv = mid - qtr - 1 + int'($urandom_range(0, 2));
                        2: iv = mid - 1 + int'($urandom_range(0, 1));
                        3: iv = mid + qtr + int'($urandom_range(0, 1));
                        4: iv = n - 1 + int'($urandom_range(0, 1));
                        default: iv = $urandom_range(mid - qtr, mid + qtr);
                    endcase
                    case ($urandom_range(0, 4))
                        0: dv = $urandom_range(0, 65535);
                        1: dv = int'(shadow_cfg.min_range_mm) + int'($urandom_range(0, 4)) - 2;
                        2: dv = int'(shadow_cfg.max_valid_mm) + int'($urandom_range(0, 4)) - 2;
                        3: dv = int'(shadow_cfg.clearance_mm) + int'($urandom_range(0, 4)) - 2;
                        default: dv = ($urandom_range(1) != 0) ? 65535 : 0;
                    endcase
                end else begin
                    iv = $urandom_range(0, 1023);
                    dv = $urandom_range(0, 65535);
                end
                if (iv < 0)
                    iv = 0;
                else if (iv > 1023)
                    iv = 1023;
                if (dv < 0)
                    dv = 0;
                else if (dv > 65535)
                    dv = 65535;
                add_item(ACT_BEAM, iv, dv, 1'($urandom_range(1)));
                added++;
            end
            // broken scans sometimes lose their scan end
            if (kind != 9 || $urandom_range(1) == 0) begin
                add_item(ACT_SCAN_END, $urandom_range(0, 1023), $urandom_range(0, 65535),
                         1'($urandom_range(1)));
                added++;
            end
        end
    endtask

    task automatic pick_pace();
        case ($urandom_range(0, 3))
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    initial begin
        int mn;
        shadow_cfg.beam_count      = 11'd512;
        shadow_cfg.min_range_mm    = 16'd0;
        shadow_cfg.max_valid_mm    = 16'd65535;
        shadow_cfg.clearance_mm    = 16'd100;
        shadow_cfg.forward_speed   = 16'sd768;
        shadow_cfg.turn_speed      = 16'sd512;
        shadow_cfg.wander_interval = 16'd200;
        shadow_cfg.evade_ticks     = 16'd50;
        drv_mode    = MODE_FWD;
        drv_timer   = '0;
        turn_left_q = 1'b0;
        left_blk    = 1'b0;
        right_blk   = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: sector edges, clearance edge, out-of-count beams
        add_item(ACT_BEAM,     127,  0,     1'b1);
        add_item(ACT_SCAN_END, 0,    0,     1'b0);
        add_item(ACT_BEAM,     128,  99,    1'b0);
        add_item(ACT_SCAN_END, 1023, 65535, 1'b1);
        add_item(ACT_BEAM,     384,  0,     1'b0);
        add_item(ACT_BEAM,     385,  0,     1'b1);
        add_item(ACT_BEAM,     512,  0,     1'b0);
        add_item(ACT_BEAM,     1023, 65535, 1'b1);
        add_item(ACT_SCAN_END, 0,    0,     1'b0);
        add_item(ACT_BEAM,     255,  100,   1'b0);
        add_item(ACT_BEAM,     256,  99,    1'b0);
        add_item(ACT_SCAN_END, 682,  21845, 1'b1);
        add_item(ACT_BEAM,     511,  0,     1'b0);
        add_item(ACT_BEAM,     0,    65535, 1'b1);
        add_item(ACT_SCAN_END, 341,  43690, 1'b0);
        add_item(ACT_BEAM,     300,  65535, 1'b0);
        add_item(ACT_SCAN_END, 0,    0,     1'b1);
        add_item(ACT_SCAN_END, 1023, 65535, 1'b0);
        wait_idle();

        apply_settings(8, 0, 65535, 100, 768, 512, 3, 2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_scans(190);
        wait_idle();

        apply_settings(2, 50, 60000, 65535, -32768, -32768, 0, 0);
        send_idle_pct = 85;
        recv_stall_pct = 0;
        queue_scans(190);
        wait_idle();

        apply_settings(1024, 65535, 65535, 0, 32767, 32767, 65534, 65535);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        queue_scans(190);
        wait_idle();

        apply_settings(16, 10, 5000, 2000, -256, 1, 5, 3);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        queue_scans(190);
        wait_idle();

        // back up the result side while scan ends keep coming
        apply_settings(4, 0, 65535, 300, 100, -100, 1, 1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (int k = 0; k < 40; k++)
            add_item(ACT_SCAN_END, $urandom_range(0, 1023), $urandom_range(0, 65535),
                     1'($urandom_range(1)));
        queue_scans(150);
        wait_idle();

        for (int p = 0; p < 2; p++) begin
            mn = $urandom_range(0, 2000);
            apply_settings(($urandom_range(3) == 0) ? $urandom_range(2, 1024)
                                                    : $urandom_range(2, 40),
                           mn, $urandom_range(mn, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 12), $urandom_range(0, 6));
            pick_pace();
            queue_scans(190);
            wait_idle();
        end

        if (expected_cmds.size() != 0) begin
            $error("%0d wheel commands never arrived", expected_cmds.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule : tb_top
`default_nettype wire
